// ===== rtl/lget_pkg.sv =====
// Shared types, constants and the luma function for the luma gradient edge block.
// No dependencies; imported by every module in rtl/.
package lget_pkg;

   // Field and register widths
   localparam int PIX_W       = 8;
   localparam int WIDTH_W     = 12;
   localparam int HEIGHT_W    = 13;
   localparam int THRESH_W    = 8;
   localparam int ROW_W       = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int LUMA_W      = 24;
   localparam int TDATA_W     = 24;

   // Frame limits and defaults
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int MAX_HEIGHT    = 4096;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
   localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(30);

   // BT.601 weights in 8.16, summing to 65536
   localparam logic [LUMA_W-1:0] W_RED   = LUMA_W'(19595);
   localparam logic [LUMA_W-1:0] W_GREEN = LUMA_W'(38470);
   localparam logic [LUMA_W-1:0] W_BLUE  = LUMA_W'(7471);

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   localparam pixel_type EDGE_PIX = '{red: '0, green: '0, blue: '0};
   localparam pixel_type FLAT_PIX = '{red: '1, green: '1, blue: '1};

   // Per-pixel control carried down the pipeline
   typedef struct packed {
      logic valid;
      logic x_last;     // rightmost column
      logic has_above;  // not the top row: the pixel above is due
      logic is_bottom;  // bottom row: the pixel itself is due
   } ctl_type;

   // One queue entry: the one or two results a pixel causes, in order
   typedef struct packed {
      pixel_type first_pix;
      logic      first_last;
      logic      has_second;
      pixel_type second_pix;
      logic      second_last;
   } entry_type;

   function automatic logic [LUMA_W-1:0] luma_of(input pixel_type p);
      logic [LUMA_W-1:0] r;
      logic [LUMA_W-1:0] g;
      logic [LUMA_W-1:0] b;
      r = LUMA_W'(p.red) * W_RED;
      g = LUMA_W'(p.green) * W_GREEN;
      b = LUMA_W'(p.blue) * W_BLUE;
      luma_of = r + g + b;
   endfunction

endpackage

// ===== rtl/lget_line_ram.sv =====
// Line memory: one row of pixels, two synchronous read ports and one write port.
// Read-first on a same-address write; depends on lget_pkg.
module lget_line_ram
   import lget_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_WIDTH,
   parameter int ADDR_W = $clog2(DEF_MAX_WIDTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pixel_type         wr_data,
   output pixel_type         rd_data_a,
   output pixel_type         rd_data_b
);

   pixel_type line_mem [DEPTH];
   pixel_type rd_a_ff;
   pixel_type rd_b_ff;

   // Reads see the old contents when the same entry is written in this cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= line_mem[rd_addr_a];
         rd_b_ff <= line_mem[rd_addr_b];
      end
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/lget_edge_eval.sv =====
// Luma and threshold stage: registers three lumas, then builds the result entry.
// Depends on lget_pkg (luma_of, ctl_type, entry_type).
module lget_edge_eval
   import lget_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             s1_ctl,
   input  pixel_type           s1_cur,
   input  pixel_type           above_pix,
   input  pixel_type           right_pix,
   input  logic [THRESH_W-1:0] edge_threshold,
   output logic                s2_valid,
   output logic                push,
   output entry_type           push_entry
);

   ctl_type           s2_ctl_ff;
   pixel_type         s2_above_ff;
   pixel_type         s2_cur_ff;
   logic [LUMA_W-1:0] la_ff;
   logic [LUMA_W-1:0] lr_ff;
   logic [LUMA_W-1:0] lb_ff;

   logic [LUMA_W-1:0] limit;
   logic [LUMA_W-1:0] diff_right;
   logic [LUMA_W-1:0] diff_below;
   logic              is_edge;
   pixel_type         res_above;
   pixel_type         res_own;

   // Control of the second stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s1_ctl;
      end
   end

   // Lumas of the pixel above, its right neighbour and the pixel below
   always_ff @(posedge clock) begin
      s2_above_ff <= above_pix;
      s2_cur_ff   <= s1_cur;
      la_ff       <= luma_of(above_pix);
      lr_ff       <= luma_of(right_pix);
      lb_ff       <= luma_of(s1_cur);
   end

   // Absolute differences against the threshold in 8.16
   always_comb begin
      limit      = {edge_threshold, 16'h0000};
      diff_right = (la_ff > lr_ff) ? la_ff - lr_ff : lr_ff - la_ff;
      diff_below = (la_ff > lb_ff) ? la_ff - lb_ff : lb_ff - la_ff;
      is_edge    = (diff_right > limit) || (diff_below > limit);
   end

   // Result of the pixel above, then the bottom-row pass-through
   always_comb begin
      res_above = s2_ctl_ff.x_last ? s2_above_ff : (is_edge ? EDGE_PIX : FLAT_PIX);
      res_own   = s2_ctl_ff.x_last ? FLAT_PIX : s2_cur_ff;

      push_entry.first_pix   = s2_ctl_ff.has_above ? res_above : res_own;
      push_entry.first_last  = s2_ctl_ff.has_above ? 1'b0 : s2_ctl_ff.x_last;
      push_entry.has_second  = s2_ctl_ff.has_above && s2_ctl_ff.is_bottom;
      push_entry.second_pix  = res_own;
      push_entry.second_last = s2_ctl_ff.x_last;

      push = s2_ctl_ff.valid && (s2_ctl_ff.has_above || s2_ctl_ff.is_bottom);
   end

   assign s2_valid = s2_ctl_ff.valid;

endmodule

// ===== rtl/lget_out_queue.sv =====
// Result queue: holds per-pixel entries and sends their one or two results as beats.
// Depends on lget_pkg (entry_type, pixel_type).
module lget_out_queue
   import lget_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH,
   parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  entry_type          push_entry,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic               rsp_tlast,
   output logic [CNT_W-1:0]   count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   entry_type        slots [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sel_ff, sel_in;

   entry_type head;
   pixel_type out_pix;
   logic      beat;
   logic      pop;

   assign head = slots[rd_ptr_ff];

   // Head entry: first result, then the second if there is one
   always_comb begin
      rsp_tvalid = (count_ff != '0);
      out_pix    = sel_ff ? head.second_pix : head.first_pix;
      rsp_tlast  = sel_ff ? head.second_last : head.first_last;
      rsp_tdata  = {out_pix.blue, out_pix.green, out_pix.red};
      beat       = rsp_tvalid && rsp_tready;
      pop        = beat && (sel_ff || !head.has_second);
   end

   // Pointer, count and result select
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      sel_in    = sel_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         sel_in    = 1'b0;
      end else if (beat) begin
         sel_in = 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sel_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sel_ff    <= sel_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

   assign count = count_ff;

   // Credit at the input must keep a free slot for every pushed entry
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(DEPTH)))
      else $error("result queue written while full");

   // The second result is only ever selected on a two-result head
   a_sel_pair: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (rsp_tvalid && head.has_second))
      else $error("second result selected without a pair");

endmodule

// ===== rtl/luma_gradient_edge_threshold.sv =====
// Top level of the luma gradient edge marker: counters, line memory, result queue.
// Depends on lget_pkg, lget_line_ram, lget_edge_eval and lget_out_queue.
//
// Usage:
//   req_* takes RGB pixels in raster order, one beat per pixel. rsp_* gives
//   result pixels: black (edge) or white (flat) for each pixel once the pixel
//   below it has arrived; the rightmost column passes through, the bottom row
//   passes through as it arrives, the bottom-right result is white with
//   rsp_tlast set. csr_* writes image_width (0), image_height (1) and
//   edge_threshold (2); write only while no frame is in progress.
// Pipeline: a result passes the first stage, the edge stage and the result queue.
// Throughput: one pixel per cycle while req_tready is high. Bottom-row pixels
//   give two results, which share the single output channel and so slow
//   that row. The rate is set by the line memory: two reads and one write per cycle.
// Stalls: a four-entry result queue sits before rsp_*; req_tready drops when
//   the queue plus the pixels in the two pipeline stages could fill it, so a
//   stalled receiver stops intake without loss.
// Reset: counters go to the first pixel of a frame and the registers to 640,
//   480 and 30. The line memory is not cleared; every entry whose value is used
//   in a frame of fixed size was written by the row before.
module luma_gradient_edge_threshold
   import lget_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: pix_red [7:0], pix_green [15:8], pix_blue [23:16]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,
   // rsp_tdata: out_red [7:0], out_green [15:8], out_blue [23:16]; frame_last on tlast
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_W-1:0]    rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int X_W    = (ADDR_W + 1 > WIDTH_W) ? ADDR_W + 1 : WIDTH_W;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic [ADDR_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   ctl_type             s1_ctl_ff, s1_ctl_in;
   pixel_type           s1_cur_ff;

   logic [X_W-1:0]      w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [X_W-1:0]      xa, x_inc, xn;
   logic [HEIGHT_W-1:0] ya, yn;
   pixel_type           cur;
   logic                accept;
   logic [CNT_W:0]      committed;

   pixel_type           above_pix;
   pixel_type           right_pix;
   logic                s2_valid;
   logic                push;
   entry_type           push_entry;
   logic [CNT_W-1:0]    q_count;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         thresh_ff <= THRESH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:    width_ff  <= csr_wr_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:   height_ff <= csr_wr_data[HEIGHT_W-1:0];
            CSR_EDGE_THRESHOLD: thresh_ff <= csr_wr_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame size clamped to what the line memory and row counter can hold
   always_comb begin
      if (width_ff == '0) begin
         w_eff = X_W'(1);
      end else if (X_W'(width_ff) > X_W'(MAX_WIDTH)) begin
         w_eff = X_W'(MAX_WIDTH);
      end else begin
         w_eff = X_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // Position of the arriving pixel and of the one after it
   always_comb begin
      xa = X_W'(col_ff);
      ya = HEIGHT_W'(row_ff);
      if (xa >= w_eff) begin
         xa = '0;
         ya = ya + HEIGHT_W'(1);
      end
      if (ya >= h_eff) begin
         ya = '0;
      end
      x_inc = xa + X_W'(1);
      xn    = x_inc;
      yn    = ya;
      if (xn >= w_eff) begin
         xn = '0;
         yn = ya + HEIGHT_W'(1);
         if (yn >= h_eff) begin
            yn = '0;
         end
      end
      col_in = xn[ADDR_W-1:0];
      row_in = yn[ROW_W-1:0];
   end

   // Intake credit: queue entries plus pixels still in flight
   always_comb begin
      committed  = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(s1_ctl_ff.valid)
                 + (CNT_W + 1)'(s2_valid);
      req_tready = committed < (CNT_W + 1)'(QUEUE_DEPTH);
      accept     = req_tvalid && req_tready;
      cur.red    = req_tdata[7:0];
      cur.green  = req_tdata[15:8];
      cur.blue   = req_tdata[23:16];

      s1_ctl_in.valid     = accept;
      s1_ctl_in.x_last    = (xa == w_eff - X_W'(1));
      s1_ctl_in.has_above = (ya != '0);
      s1_ctl_in.is_bottom = (ya == h_eff - HEIGHT_W'(1));
   end

   // Position counters and first pipeline stage
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff <= cur;
      end
   end

   // Previous row: read above and above-right, replace above with this pixel
   lget_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_ram (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (xa[ADDR_W-1:0]),
      .rd_addr_b (x_inc[ADDR_W-1:0]),
      .wr_en     (accept),
      .wr_addr   (xa[ADDR_W-1:0]),
      .wr_data   (cur),
      .rd_data_a (above_pix),
      .rd_data_b (right_pix)
   );

   lget_edge_eval u_edge_eval (
      .clock          (clock),
      .reset          (reset),
      .s1_ctl         (s1_ctl_ff),
      .s1_cur         (s1_cur_ff),
      .above_pix      (above_pix),
      .right_pix      (right_pix),
      .edge_threshold (thresh_ff),
      .s2_valid       (s2_valid),
      .push           (push),
      .push_entry     (push_entry)
   );

   lget_out_queue #(
      .DEPTH (QUEUE_DEPTH),
      .CNT_W (CNT_W)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .count      (q_count)
   );

   // The frame's final result is always the white bottom-right pixel
   a_last_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == '1))
      else $error("end-of-frame result is not white");

endmodule

// ===== tb/sv/tb_luma_gradient_edge_threshold.sv =====
// Self-checking testbench for luma_gradient_edge_threshold: streams RGB frames of
// directed and random sizes, predicts every result beat and checks it on rsp_*.
// Depends on lget_pkg and the RTL under rtl/.
module tb_luma_gradient_edge_threshold
   import lget_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned RANDOM_ITEMS = 1600;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES  = 300;

   // BT.601 weights in 16.16
   localparam int unsigned WEIGHT_RED   = 19595;
   localparam int unsigned WEIGHT_GREEN = 38470;
   localparam int unsigned WEIGHT_BLUE  = 7471;

   typedef enum int {
      MODE_RX_STALLS,   // sender rarely idles, receiver mostly stalls
      MODE_TX_GAPS,     // sender mostly idles, receiver rarely stalls
      MODE_FREE_RUN     // neither side idles
   } flow_mode_type;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } out_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // req_tdata: pix_red [7:0], pix_green [15:8], pix_blue [23:16]
   logic [TDATA_W-1:0]    req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // rsp_tdata: out_red [7:0], out_green [15:8], out_blue [23:16]
   logic [TDATA_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // Predictor state: registers, raster position and the previous row
   logic [WIDTH_W-1:0]    reg_width = WIDTH_RST;
   logic [HEIGHT_W-1:0]   reg_height = HEIGHT_RST;
   logic [THRESH_W-1:0]   reg_threshold = THRESH_RST;
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;
   pixel_type             prev_row [DEF_MAX_WIDTH];

   pixel_type             pixel_backlog [$];
   out_beat_type          pending_results [$];
   flow_mode_type         flow_mode = MODE_FREE_RUN;
   logic                  req_pause = 1'b0;
   int unsigned           rsp_hold_left = 0;
   int unsigned           fail_count = 0;
   int unsigned           cycle_count = 0;

   luma_gradient_edge_threshold i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit roll_percent(int unsigned pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   function automatic int unsigned eff_width();
      int unsigned w;
      w = reg_width;
      if (w < 1) w = 1;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = reg_height;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   function automatic int unsigned luma_16q16(pixel_type p);
      return WEIGHT_RED * p.red + WEIGHT_GREEN * p.green + WEIGHT_BLUE * p.blue;
   endfunction

   function automatic int unsigned luma_gap(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Works out the result beats one accepted pixel causes and advances the raster
   function automatic void mark_edges(pixel_type cur);
      int unsigned w, h, x, y, limit, l_above;
      pixel_type   above;
      out_beat_type beat;
      bit          is_edge;
      w = eff_width();
      h = eff_height();
      x = col_pos;
      y = row_pos;
      if (x >= w) begin
         x = 0;
         y++;
      end
      if (y >= h) y = 0;
      limit = int'(reg_threshold) << 16;

      // pixel above is due once its lower neighbour arrives
      if (y >= 1) begin
         above = prev_row[x];
         if (x == w - 1) begin
            beat.pix = above;
         end else begin
            l_above = luma_16q16(above);
            is_edge = luma_gap(l_above, luma_16q16(prev_row[x + 1])) > limit ||
                      luma_gap(l_above, luma_16q16(cur)) > limit;
            beat.pix = is_edge ? EDGE_PIX : FLAT_PIX;
         end
         beat.last = 1'b0;
         pending_results.push_back(beat);
      end
      prev_row[x] = cur;

      // bottom row passes straight through, bottom-right is white and closes the frame
      if (y == h - 1) begin
         beat.pix  = (x == w - 1) ? FLAT_PIX : cur;
         beat.last = (x == w - 1);
         pending_results.push_back(beat);
      end

      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      col_pos = x;
      row_pos = y;
   endfunction

   // Request driver: holds a beat until taken, predicts on acceptance
   always @(posedge clock) begin : drive_req
      bit offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            mark_edges(pixel_backlog[0]);
            void'(pixel_backlog.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            offer = pixel_backlog.size() > 0 && !req_pause;
            case (flow_mode)
               MODE_RX_STALLS: if (roll_percent(6)) offer = 1'b0;
               MODE_TX_GAPS:   if (roll_percent(87)) offer = 1'b0;
               default: ;
            endcase
            req_tvalid <= offer;
            if (offer) begin
               req_tdata <= {pixel_backlog[0].blue, pixel_backlog[0].green,
                             pixel_backlog[0].red};
            end
         end
      end
   end

   // Receiver back-pressure, including a long hold-off on request
   always @(posedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_tready    <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         case (flow_mode)
            MODE_RX_STALLS: rsp_tready <= !roll_percent(87);
            MODE_TX_GAPS:   rsp_tready <= !roll_percent(6);
            default:        rsp_tready <= 1'b1;
         endcase
      end
   end

   // Result monitor: each beat against the oldest expectation
   always @(posedge clock) begin : check_rsp
      out_beat_type want;
      pixel_type    got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red   = rsp_tdata[7:0];
         got.green = rsp_tdata[15:8];
         got.blue  = rsp_tdata[23:16];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat %h last %b", $time, got, rsp_tlast);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.red !== want.pix.red) begin
               $display("%0t: out_red expected %0d actual %0d", $time, want.pix.red, got.red);
               fail_count++;
            end
            if (got.green !== want.pix.green) begin
               $display("%0t: out_green expected %0d actual %0d", $time, want.pix.green,
                        got.green);
               fail_count++;
            end
            if (got.blue !== want.pix.blue) begin
               $display("%0t: out_blue expected %0d actual %0d", $time, want.pix.blue,
                        got.blue);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: frame_last expected %b actual %b", $time, want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("luma_gradient_edge_threshold verification failed");
         $finish;
      end
   end

   // Waits until every beat is sent and answered, then lets the pipeline empty
   task automatic wait_drained();
      while (pixel_backlog.size() != 0 || req_tvalid || pending_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:    reg_width     = value[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT:   reg_height    = value[HEIGHT_W-1:0];
         CSR_EDGE_THRESHOLD: reg_threshold = value[THRESH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_frame(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h,
                            logic [CSR_DATA_W-1:0] t);
      wait_drained();
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_EDGE_THRESHOLD, t);
      @(negedge clock);
   endtask

   // Fills one frame: fully random, or a smooth field with small ripples and jumps
   task automatic queue_frame(int unsigned n_pix);
      pixel_type base;
      pixel_type p;
      bit        smooth;
      smooth = 1'($urandom_range(1, 0));
      base   = pixel_type'(24'($urandom_range(24'hFFFFFF, 0)));
      for (int unsigned i = 0; i < n_pix; i++) begin
         if (!smooth || roll_percent(5)) begin
            p = pixel_type'(24'($urandom_range(24'hFFFFFF, 0)));
         end else begin
            p.red   = base.red ^ PIX_W'($urandom_range(3, 0));
            p.green = base.green ^ PIX_W'($urandom_range(3, 0));
            p.blue  = base.blue ^ PIX_W'($urandom_range(3, 0));
         end
         pixel_backlog.push_back(p);
      end
   endtask

   initial begin : stimulus
      int unsigned           frame_idx;
      int unsigned           random_items;
      int unsigned           n_pix;
      logic [CSR_DATA_W-1:0] new_w;
      logic [CSR_DATA_W-1:0] new_h;
      logic [CSR_DATA_W-1:0] new_t;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: channel extremes against a zero threshold
      set_frame(4, 3, 0);
      pixel_backlog = '{pixel_type'(24'h000000), pixel_type'(24'hFFFFFF),
                        pixel_type'(24'hFF0000), pixel_type'(24'h00FF00),
                        pixel_type'(24'h0000FF), pixel_type'(24'h0000FF),
                        pixel_type'(24'h010000), pixel_type'(24'h000000),
                        pixel_type'(24'hFFFFFF), pixel_type'(24'h7F7F7F),
                        pixel_type'(24'h808080), pixel_type'(24'h123456)};
      // full-scale difference equal to the top threshold stays flat
      set_frame(2, 2, 255);
      pixel_backlog = '{pixel_type'(24'h000000), pixel_type'(24'hFFFFFF),
                        pixel_type'(24'hFFFFFF), pixel_type'(24'h000000)};
      // single column: every pixel in the rightmost column
      set_frame(1, 3, 30);
      pixel_backlog = '{pixel_type'(24'hA5A5A5), pixel_type'(24'h5A5A5A),
                        pixel_type'(24'hFF00FF)};
      // single row: only the bottom row is emitted
      set_frame(3, 1, 128);
      pixel_backlog = '{pixel_type'(24'h00FFFF), pixel_type'(24'hC0FFEE),
                        pixel_type'(24'h0F0F0F)};

      // Random frames, with a few directed sizes among them
      frame_idx    = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items < RANDOM_ITEMS / 3)
            flow_mode = MODE_RX_STALLS;
         else if (random_items < 2 * RANDOM_ITEMS / 3)
            flow_mode = MODE_TX_GAPS;
         else
            flow_mode = MODE_FREE_RUN;

         new_w    = CSR_DATA_W'(reg_width);
         new_h    = CSR_DATA_W'(reg_height);
         new_t    = CSR_DATA_W'(reg_threshold);
         if (frame_idx == 3) begin
            new_w = 12;
            new_h = 6;
         end else if (frame_idx == 12) begin
            // zero width acts as one column
            new_w = 0;
            new_h = 5;
         end else if (frame_idx == 24) begin
            // zero height acts as one row; width bit 12 is dropped by the register
            new_w = 13'h1000 | 13'd9;
            new_h = 0;
         end else if ($urandom_range(2, 0) != 0) begin
            case ($urandom_range(19, 0))
               0:       new_w = 0;
               1:       new_w = 1;
               2:       new_w = 13'h1000 | CSR_DATA_W'($urandom_range(12, 2));
               3, 4:    new_w = CSR_DATA_W'($urandom_range(64, 13));
               default: new_w = CSR_DATA_W'($urandom_range(12, 2));
            endcase
            case ($urandom_range(9, 0))
               0:       new_h = 0;
               1:       new_h = 1;
               default: new_h = CSR_DATA_W'($urandom_range(6, 2));
            endcase
            case ($urandom_range(5, 0))
               0:       new_t = 0;
               1:       new_t = 255;
               2:       new_t = 13'h1F00 | CSR_DATA_W'($urandom_range(255, 0));
               default: new_t = CSR_DATA_W'($urandom_range(255, 0));
            endcase
         end
         if (new_w[WIDTH_W-1:0] != reg_width || new_h != reg_height ||
             new_t[THRESH_W-1:0] != reg_threshold)
            set_frame(new_w, new_h, new_t);

         n_pix = eff_width() * eff_height();
         // long receiver hold-off while the sender keeps offering
         if (frame_idx == 3) rsp_hold_left = HOLD_CYCLES;
         queue_frame(n_pix);

         // sender pauses mid-frame until all outstanding results are in
         if (frame_idx == 6) begin
            while (pixel_backlog.size() > n_pix / 2) @(negedge clock);
            req_pause = 1'b1;
            while (req_tvalid || pending_results.size() != 0) @(negedge clock);
            req_pause = 1'b0;
         end

         random_items += n_pix;
         frame_idx++;
      end

      wait_drained();
      if (fail_count == 0)
         $display("luma_gradient_edge_threshold verification clean");
      else
         $display("luma_gradient_edge_threshold verification failed");
      $finish;
   end

endmodule
